// ===== hw/rtl/sgs_pkg.sv =====
// ---------------------------------------------------------------------------
// sgs_pkg: shared types and constants of the sky gradient shader
// Widths of the direction and color fields and the records that travel
// along the divider and square root cell chains.
// ---------------------------------------------------------------------------
`default_nettype none
package sgs_pkg;

  localparam int DirBits  = 16;
  localparam int ChBits   = 8;
  localparam int RgbBits  = 3 * ChBits;
  localparam int SqBits   = 2 * DirBits;      // one squared component
  localparam int FracBits = 32;               // quotient bits, Q0.32
  localparam int RootBits = FracBits / 2 + 1; // weight, Q1.16, at most 1.0
  localparam int DivCells = FracBits;
  localparam int SqrtCells = FracBits / 2 + 1;
  localparam int AddrBits = 4;
  localparam int DataBits = 32;

  localparam logic [AddrBits-1:0] AddrHorizon = AddrBits'(0);
  localparam logic [AddrBits-1:0] AddrSky     = AddrBits'(4);
  localparam logic [AddrBits-1:0] AddrGround  = AddrBits'(8);

  typedef struct packed {
    logic                vld;
    logic                zero;
    logic                full;
    logic                ypos;
    logic [SqBits-1:0]   r;
    logic [SqBits-1:0]   den;
    logic [FracBits-1:0] q;
  } div_t;

  typedef struct packed {
    logic              vld;
    logic              zero;
    logic              ypos;
    logic [FracBits:0] v;
    logic [FracBits:0] res;
    logic [FracBits:0] msk;
  } sqrt_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sky_gradient_shade.sv =====
// ---------------------------------------------------------------------------
// sky_gradient_shade: vertical sky gradient shader
// Normalizes a view direction and blends horizon toward sky or ground.
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one direction per transfer, tdata = {dir_z, dir_y, dir_x}.
//   m_axis returns one color per input, tdata = {blue, green, red},
//   tuser = zero_direction (set when the input vector was all zero).
//   colors are written over apb at 0x0 horizon, 0x4 sky, 0x8 ground;
//   the user must only write while no pixel is in flight (not enforced).
//   one pixel is accepted every cycle unless the output stalls. stages:
//   magnitude, square, 32 divider cells, 17 square root cells, multiply, output.
//   the divider and root chains each hold one pixel per cell.
//   when the receiver stalls the whole pipeline holds and s_axis_tready
//   drops; a waiting result stalls every stage, bubbles included.
//   reset empties the pipeline and clears all three colors to black.
// ---------------------------------------------------------------------------
`default_nettype none
module sky_gradient_shade import sgs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [3*DirBits-1:0] s_axis_tdata,  // dir_x, dir_y, dir_z
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [RgbBits-1:0]       m_axis_tdata,  // red, green, blue
  output logic                     m_axis_tuser,  // zero_direction
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0]      prdata,
  output logic                     pready
);

  logic               en;
  logic [RgbBits-1:0] horizon_q, sky_q, ground_q;
  logic               wr;

  // configuration
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= '0;
      sky_q     <= '0;
      ground_q  <= '0;
    end else if (wr) begin
      case (paddr)
        AddrHorizon: horizon_q <= pwdata[RgbBits-1:0];
        AddrSky:     sky_q     <= pwdata[RgbBits-1:0];
        AddrGround:  ground_q  <= pwdata[RgbBits-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrHorizon: prdata = DataBits'(horizon_q);
      AddrSky:     prdata = DataBits'(sky_q);
      AddrGround:  prdata = DataBits'(ground_q);
      default:     prdata = '0;
    endcase
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // magnitudes
  logic [DirBits-1:0] dx, dy, dz;
  logic               v0_q, v1_q, ypos0_q, ypos1_q;
  logic [DirBits-1:0] ax_q, ay_q, az_q;
  logic [SqBits-1:0]  y2_q, n2_q;

  assign dx = s_axis_tdata[0 +: DirBits];
  assign dy = s_axis_tdata[DirBits +: DirBits];
  assign dz = s_axis_tdata[2*DirBits +: DirBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q    <= dx[DirBits-1] ? (~dx + 1'b1) : dx;
      ay_q    <= dy[DirBits-1] ? (~dy + 1'b1) : dy;
      az_q    <= dz[DirBits-1] ? (~dz + 1'b1) : dz;
      ypos0_q <= !dy[DirBits-1] && (dy != '0);
      ypos1_q <= ypos0_q;
      y2_q    <= ay_q * ay_q;
      n2_q    <= ax_q * ax_q + ay_q * ay_q + az_q * az_q;
    end
  end

  // divider chain
  div_t div_s [DivCells+1];

  always_comb begin
    div_s[0].vld  = v1_q;
    div_s[0].zero = n2_q == '0;
    div_s[0].full = y2_q >= n2_q;
    div_s[0].ypos = ypos1_q;
    div_s[0].r    = y2_q;
    div_s[0].den  = n2_q;
    div_s[0].q    = '0;
  end

  for (genvar i = 0; i < DivCells; i++) begin : g_div
    sgs_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .in_i  (div_s[i]),
      .out_o (div_s[i+1])
    );
  end

  // square root chain
  sqrt_t sq_s [SqrtCells+1];

  always_comb begin
    sq_s[0].vld  = div_s[DivCells].vld;
    sq_s[0].zero = div_s[DivCells].zero;
    sq_s[0].ypos = div_s[DivCells].ypos;
    sq_s[0].v    = div_s[DivCells].full ? {1'b1, {FracBits{1'b0}}}
                                        : {1'b0, div_s[DivCells].q};
    sq_s[0].res  = '0;
    sq_s[0].msk  = {1'b1, {FracBits{1'b0}}};
  end

  for (genvar i = 0; i < SqrtCells; i++) begin : g_sqrt
    sgs_sqrt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .in_i  (sq_s[i]),
      .out_o (sq_s[i+1])
    );
  end

  // blend result keeps the register order, red in the top byte
  logic [RgbBits-1:0] blend_rgb;

  sgs_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (sq_s[SqrtCells].vld),
    .zero_i   (sq_s[SqrtCells].zero),
    .ypos_i   (sq_s[SqrtCells].ypos),
    .t_i      (sq_s[SqrtCells].res[RootBits-1:0]),
    .horizon_i(horizon_q),
    .sky_i    (sky_q),
    .ground_i (ground_q),
    .vld_o    (m_axis_tvalid),
    .zero_o   (m_axis_tuser),
    .rgb_o    (blend_rgb)
  );

  assign m_axis_tdata = {blend_rgb[0 +: ChBits], blend_rgb[ChBits +: ChBits],
                         blend_rgb[2*ChBits +: ChBits]};

  // horizon color is reversed channel order on the output bus
  logic [RgbBits-1:0] horizon_out;
  assign horizon_out = {horizon_q[0 +: ChBits], horizon_q[ChBits +: ChBits],
                        horizon_q[2*ChBits +: ChBits]};

  a_zero_horizon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == horizon_out)
    else $error("zero direction without horizon color");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_s[SqrtCells].vld |-> sq_s[SqrtCells].res <= (FracBits+1)'(1 << (FracBits/2)))
    else $error("weight above one");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during output stall");

endmodule
`default_nettype wire

// ===== hw/rtl/sgs_div_cell.sv =====
// ---------------------------------------------------------------------------
// sgs_div_cell: one restoring division step
// Produces one quotient bit of y^2 * 2^32 / n2 and hands the partial
// remainder to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none
module sgs_div_cell import sgs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  div_t      in_i,
  output div_t      out_o
);

  logic              vld_q;
  div_t              pay_q;
  div_t              pay_d;
  logic [SqBits:0]   r2;
  logic [SqBits:0]   diff;
  logic              ge;

  assign r2   = {in_i.r, 1'b0};
  assign ge   = r2 >= {1'b0, in_i.den};
  assign diff = r2 - {1'b0, in_i.den};

  always_comb begin
    pay_d   = in_i;
    pay_d.r = ge ? diff[SqBits-1:0] : r2[SqBits-1:0];
    pay_d.q = {in_i.q[FracBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    out_o     = pay_q;
    out_o.vld = vld_q;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sgs_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// sgs_sqrt_cell: one digit step of the integer square root
// Decides one result bit and passes value, root and bit mask onward.
// ---------------------------------------------------------------------------
`default_nettype none
module sgs_sqrt_cell import sgs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  sqrt_t     in_i,
  output sqrt_t     out_o
);

  logic                vld_q;
  sqrt_t               pay_q;
  sqrt_t               pay_d;
  logic [FracBits+1:0] sum;
  logic                ge;

  assign sum = {1'b0, in_i.res} + {1'b0, in_i.msk};
  assign ge  = {1'b0, in_i.v} >= sum;

  always_comb begin
    pay_d     = in_i;
    pay_d.v   = ge ? (in_i.v - sum[FracBits:0]) : in_i.v;
    pay_d.res = ge ? ((in_i.res >> 1) + in_i.msk) : (in_i.res >> 1);
    pay_d.msk = in_i.msk >> 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  always_comb begin
    out_o     = pay_q;
    out_o.vld = vld_q;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sgs_blend.sv =====
// ---------------------------------------------------------------------------
// sgs_blend: color blend and output register
// Multiplies the color difference by the weight, then adds the horizon
// color with rounding and holds the result for the output channel.
// ---------------------------------------------------------------------------
`default_nettype none
module sgs_blend import sgs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               vld_i,
  input  wire logic               zero_i,
  input  wire logic               ypos_i,
  input  wire logic [RootBits-1:0] t_i,
  input  wire logic [RgbBits-1:0] horizon_i,
  input  wire logic [RgbBits-1:0] sky_i,
  input  wire logic [RgbBits-1:0] ground_i,
  output logic                    vld_o,
  output logic                    zero_o,
  output logic [RgbBits-1:0]      rgb_o
);

  localparam int ProdBits = ChBits + RootBits + 2;
  localparam int SumBits  = ProdBits + 2;

  logic                       mvld_q;
  logic                       mzero_q;
  logic [RgbBits-1:0]         mh_q;
  logic signed [ProdBits-1:0] prod_q [3];
  logic signed [ProdBits-1:0] prod_d [3];
  logic [RgbBits-1:0]         tgt;
  logic [RootBits-1:0]        t;
  logic [RgbBits-1:0]         rgb_d;
  logic                       ovld_q;
  logic                       ozero_q;
  logic [RgbBits-1:0]         rgb_q;

  assign tgt = ypos_i ? sky_i : ground_i;
  assign t   = zero_i ? '0 : t_i;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_d[c] = ProdBits'(
        $signed({1'b0, tgt[c*ChBits +: ChBits]}) - $signed({1'b0, horizon_i[c*ChBits +: ChBits]}))
        * $signed({1'b0, t});
    end
  end

  always_comb begin
    logic signed [SumBits-1:0] s;
    s = '0;
    rgb_d = '0;
    for (int c = 0; c < 3; c++) begin
      s = $signed({{(SumBits-ChBits-16){1'b0}}, mh_q[c*ChBits +: ChBits], 16'h0})
          + SumBits'(prod_q[c]) + SumBits'(32768);
      if (s < 0) begin
        rgb_d[c*ChBits +: ChBits] = '0;
      end else if (s[SumBits-1:16] > SumBits'({ChBits{1'b1}})) begin
        rgb_d[c*ChBits +: ChBits] = '1;
      end else begin
        rgb_d[c*ChBits +: ChBits] = s[16 +: ChBits];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= 1'b0;
      ovld_q <= 1'b0;
    end else if (en_i) begin
      mvld_q <= vld_i;
      ovld_q <= mvld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mzero_q <= zero_i;
      mh_q    <= horizon_i;
      prod_q  <= prod_d;
      ozero_q <= mzero_q;
      rgb_q   <= rgb_d;
    end
  end

  assign vld_o  = ovld_q;
  assign zero_o = ozero_q;
  assign rgb_o  = rgb_q;

endmodule
`default_nettype wire

// ===== sim/sgs_checker.sv =====
// ---------------------------------------------------------------------------
// sgs_checker: result checker of the sky gradient shader
// Watches both streams, computes the expected color for every accepted
// direction and compares it with every accepted color transfer.
// ---------------------------------------------------------------------------
module sgs_checker import sgs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_ready_i,
  input  logic [3*DirBits-1:0] s_data_i,
  input  logic                 m_valid_i,
  input  logic                 m_ready_i,
  input  logic [RgbBits-1:0]   m_data_i,
  input  logic                 m_user_i,
  input  logic [RgbBits-1:0]   horizon_i,
  input  logic [RgbBits-1:0]   sky_i,
  input  logic [RgbBits-1:0]   ground_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   colors_o,
  output int                   zeros_o
);

  typedef struct packed {
    logic             zero;
    logic [ChBits-1:0] blue;
    logic [ChBits-1:0] green;
    logic [ChBits-1:0] red;
  } color_t;

  color_t colors_q[$];

  function automatic logic [DirBits:0] magnitude(logic [DirBits-1:0] raw);
    logic [DirBits:0] m;
    m = raw[DirBits-1] ? ({1'b0, ~raw} + 1) : {1'b0, raw};
    return m;
  endfunction

  // weight floor(2^16 * |y| / |v|) from exact integers
  function automatic longint unsigned up_weight(longint unsigned y2, longint unsigned n2);
    longint unsigned q, root, b;
    q = (y2 * 64'd65536 * 64'd65536) / n2;
    if (y2 >= n2) q = 64'h1_0000_0000;
    root = 0;
    for (int i = 16; i >= 0; i--) begin
      b = root | (64'd1 << i);
      if (b * b <= q) root = b;
    end
    return root;
  endfunction

  function automatic logic [ChBits-1:0] mix(longint unsigned h, longint unsigned tg,
                                             longint unsigned w);
    longint s;
    s = longint'(h) * 65536 + (longint'(tg) - longint'(h)) * longint'(w) + 32768;
    if (s < 0) s = 0;
    s = s >>> 16;
    if (s > 255) s = 255;
    return s[ChBits-1:0];
  endfunction

  function automatic color_t shade(logic [3*DirBits-1:0] d);
    logic [DirBits:0] ax, ay, az;
    longint unsigned y2, n2, w;
    logic [RgbBits-1:0] tg;
    color_t c;
    ax = magnitude(d[DirBits-1:0]);
    ay = magnitude(d[2*DirBits-1:DirBits]);
    az = magnitude(d[3*DirBits-1:2*DirBits]);
    y2 = ay * ay;
    n2 = ax * ax + y2 + az * az;
    tg = (!d[2*DirBits-1] && ay != 0) ? sky_i : ground_i;
    w = (n2 == 0) ? 0 : up_weight(y2, n2);
    c.zero  = (n2 == 0);
    c.red   = mix(horizon_i[3*ChBits-1:2*ChBits], tg[3*ChBits-1:2*ChBits], w);
    c.green = mix(horizon_i[2*ChBits-1:ChBits], tg[2*ChBits-1:ChBits], w);
    c.blue  = mix(horizon_i[ChBits-1:0], tg[ChBits-1:0], w);
    return c;
  endfunction

  assign pending_o = colors_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    color_t e;
    int     n;
    n = 0;
    if (!rst_ni) begin
      colors_q.delete();
      errors_o <= 0;
      colors_o <= 0;
      zeros_o  <= 0;
    end else begin
      if (s_valid_i && s_ready_i) colors_q.push_back(shade(s_data_i));
      if (m_valid_i && m_ready_i) begin
        colors_o <= colors_o + 1;
        if (m_user_i) zeros_o <= zeros_o + 1;
        if (colors_q.size() == 0) begin
          $error("color transfer with no direction waiting");
          n++;
        end else begin
          e = colors_q.pop_front();
          if (e.red !== m_data_i[ChBits-1:0]) begin
            $error("red: expected %0d, got %0d", e.red, m_data_i[ChBits-1:0]);
            n++;
          end
          if (e.green !== m_data_i[2*ChBits-1:ChBits]) begin
            $error("green: expected %0d, got %0d", e.green, m_data_i[2*ChBits-1:ChBits]);
            n++;
          end
          if (e.blue !== m_data_i[3*ChBits-1:2*ChBits]) begin
            $error("blue: expected %0d, got %0d", e.blue, m_data_i[3*ChBits-1:2*ChBits]);
            n++;
          end
          if (e.zero !== m_user_i) begin
            $error("zero_direction: expected %0d, got %0d", e.zero, m_user_i);
            n++;
          end
        end
        errors_o <= errors_o + n;
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb: testbench of the sky gradient shader
// Writes several color sets over apb, streams directed and random view
// directions with bursty input and a stalling output, and counts mismatches.
// ---------------------------------------------------------------------------
module tb import sgs_pkg::*;;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [3*DirBits-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [RgbBits-1:0]   m_tdata;
  logic                 m_tuser;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrBits-1:0]  paddr = '0;
  logic [DataBits-1:0]  pwdata = '0;
  logic [DataBits-1:0]  prdata;
  logic                 pready;
  logic [RgbBits-1:0]   horizon = '0, sky = '0, ground = '0;
  int                   errors, pending, colors, zeros, sent;
  bit                   hold_off = 1'b0;

  always #4 clk_i = ~clk_i;

  sky_gradient_shade uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .m_axis_tuser(m_tuser),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sgs_checker chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_tvalid), .s_ready_i(s_tready), .s_data_i(s_tdata),
    .m_valid_i(m_tvalid), .m_ready_i(m_tready), .m_data_i(m_tdata), .m_user_i(m_tuser),
    .horizon_i(horizon), .sky_i(sky), .ground_i(ground),
    .errors_o(errors), .pending_o(pending), .colors_o(colors), .zeros_o(zeros)
  );

  task automatic write_color(input logic [AddrBits-1:0] addr, input logic [DataBits-1:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (addr)
      AddrHorizon: horizon = val[RgbBits-1:0];
      AddrSky:     sky = val[RgbBits-1:0];
      AddrGround:  ground = val[RgbBits-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_colors(input logic [DataBits-1:0] h, s, g);
    write_color(AddrHorizon, h);
    write_color(AddrSky, s);
    write_color(AddrGround, g);
  endtask

  // one direction, held until its transfer; bursts with random gaps
  task automatic send_dir(input logic [DirBits-1:0] x, y, z);
    s_tvalid <= 1'b1;
    s_tdata <= {z, y, x};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
    if ($urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  function automatic logic [DirBits-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'(signed'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic random_dirs(input int n);
    for (int i = 0; i < n; i++) send_dir(rand_comp(), rand_comp(), rand_comp());
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (hold_off) m_tready <= 1'b0;
      else if (phase % 400 < 100) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_colors(32'hff8040, 32'h0000ff, 32'h00ff00);
    send_dir(16'h0000, 16'h0000, 16'h0000);
    send_dir(16'h0000, 16'h4000, 16'h0000);
    send_dir(16'h0000, 16'hc000, 16'h0000);
    send_dir(16'h4000, 16'h0000, 16'h0000);
    send_dir(16'h0000, 16'h0000, 16'h8000);
    send_dir(16'h8000, 16'h8000, 16'h8000);
    send_dir(16'h7fff, 16'h7fff, 16'h7fff);
    send_dir(16'h0000, 16'h7fff, 16'h0000);
    send_dir(16'h0000, 16'h8000, 16'h0000);
    send_dir(16'h8000, 16'h0001, 16'h7fff);
    send_dir(16'h0001, 16'hffff, 16'h0001);
    send_dir(16'h2d41, 16'h2d41, 16'h0000);
    send_dir(16'hffff, 16'hffff, 16'hffff);
    send_dir(16'h5555, 16'haaaa, 16'h5555);
    drain();
    set_colors(32'hffffff, 32'hffffff, 32'h000000);
    send_dir(16'h0000, 16'h0001, 16'h0000);
    send_dir(16'h0000, 16'hffff, 16'h0000);
    send_dir(16'h1234, 16'h7fff, 16'hedcb);
    random_dirs(300);
    drain();
    // long hold-off so the pipeline fills and tready drops
    hold_off = 1'b1;
    fork
      random_dirs(120);
      begin
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();
    set_colors(32'h000000, 32'h000000, 32'hffffff);
    random_dirs(300);
    drain();
    for (int k = 0; k < 3; k++) begin
      set_colors($urandom, $urandom, $urandom);
      random_dirs(260);
      drain();
    end
    $display("directions sent: %0d, colors checked: %0d, zero vectors: %0d",
             sent, colors, zeros);
    $display("color sets included black, white and random registers");
    if (errors == 0 && pending == 0) begin
      $display("sky_gradient_shade: match");
    end else begin
      $display("sky_gradient_shade: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sky_gradient_shade: mismatch");
    $finish;
  end

endmodule
